// File: hdl/lz4bd_pkg.sv
// Shared types, codes and helpers of the LZ4 block decompressor.
// Used by lz4_block_decompressor; depends on nothing else.
package lz4bd_pkg;

  localparam int LEN_W = 25;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] CAP_RESET = 25'h1000000;
  localparam logic [LEN_W-1:0] MIN_MATCH = 25'd4;
  localparam logic [3:0] NIBBLE_EXT = 4'hF;
  localparam logic [7:0] BYTE_EXT = 8'd255;
  localparam int HISTORY_DEPTH_DEF = 65536;

  // register index on the configuration port
  localparam logic REG_OUT_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_MALFORM  = 2'd1,
    ERR_CAPACITY = 2'd2,
    ERR_BUSY     = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    PH_TOKEN   = 3'd0,
    PH_LITEXT  = 3'd1,
    PH_LITERAL = 3'd2,
    PH_OFFLO   = 3'd3,
    PH_OFFHI   = 3'd4,
    PH_MATEXT  = 3'd5,
    PH_COPY    = 3'd6
  } phase_t;

  // one result in flight between decode and the output register
  typedef struct packed {
    logic             show;   // out_valid of the result
    logic             hist;   // byte comes from the history read
    logic             wr;     // byte goes into history
    logic [7:0]       lit;    // literal byte
    logic             done;
    err_t             err;
    logic [LEN_W-1:0] total;
    logic             wants;
  } stage_t;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
  endfunction

endpackage

// File: hdl/lz4_block_decompressor.sv
// Top level of the LZ4 block decompressor: decode, history RAM, output register.
// Depends on lz4bd_pkg.
//
// The block takes one request per cycle while in_stall is low, a compressed
// byte or a copy tick, and returns exactly one result for each, through the
// synchronous read of the 64 KiB history RAM and then the output register.
// Header decode, length checks and counters settle in the accept cycle, so
// the sustained rate is one request per cycle while res_stall stays low; the
// single write port of the history RAM, written as each result leaves the
// read stage, sets that figure, and a read of the entry being written in the
// same cycle is forwarded. The history needs no clearing pass after reset.
module lz4_block_decompressor #(
  parameter int HISTORY_DEPTH = lz4bd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       cmd,
  input  logic [7:0]                 in_byte,
  input  logic                       is_last,
  // result channel
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic                       out_valid,
  output logic [7:0]                 out_byte,
  output logic                       block_done,
  output logic [1:0]                 error_code,
  output logic [lz4bd_pkg::LEN_W-1:0] out_total,
  output logic                       wants_byte,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lz4bd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  // configuration
  logic [LEN_W-1:0] out_capacity;

  // block state
  phase_t           phase, phase_next;
  logic [LEN_W-1:0] lit_left, lit_left_next;
  logic             match_ext, match_ext_next;
  logic [LEN_W-1:0] mlen, mlen_next;
  logic [15:0]      moff, moff_next;
  logic [LEN_W-1:0] copy_left, copy_left_next;
  logic [LEN_W-1:0] produced, produced_next;
  logic             ending, ending_next;
  logic             discarding, discarding_next;

  // decode events
  logic             fin;
  err_t             fin_code;
  logic             emit_lit, emit_hist;

  // pipeline
  logic             accept;
  logic             s2_valid, s2_move;
  stage_t           s2, s2_next;
  logic [AW-1:0]    s2_waddr;
  logic [AW-1:0]    raddr;
  logic [7:0]       rdata, hist_data, s2_wdata;
  logic             fwd_hit;
  logic [7:0]       fwd_byte;
  logic [7:0]       history [HISTORY_DEPTH];

  // decode helpers
  logic [LEN_W:0]   room;
  logic [LEN_W-1:0] lit_cand, len_cand;
  logic [15:0]      off_new, off_cand;
  logic             lit_over, len_over, off_bad;

  assign pready   = 1'b1;
  assign s2_move  = s2_valid && (!res_valid || !res_stall);
  assign in_stall = s2_valid && !s2_move;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_OUT_CAPACITY)) begin
      out_capacity <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_OUT_CAPACITY) begin
      prdata = {{(32-LEN_W){1'b0}}, out_capacity};
    end
  end

  // length checks against the room left under the capacity
  assign room     = {1'b0, out_capacity} - {1'b0, produced};
  assign lit_cand = (phase == PH_TOKEN) ? {{(LEN_W-4){1'b0}}, in_byte[7:4]}
                                        : sat_add(lit_left, {{(LEN_W-8){1'b0}}, in_byte});
  assign len_cand = (phase == PH_MATEXT) ? sat_add(mlen, {{(LEN_W-8){1'b0}}, in_byte})
                                         : mlen;
  assign off_new  = {in_byte, moff[7:0]};
  assign off_cand = (phase == PH_OFFHI) ? off_new : moff;
  assign lit_over = room[LEN_W] || ({1'b0, lit_cand} > room);
  assign len_over = room[LEN_W] || ({1'b0, len_cand} > room);
  assign off_bad  = {{(LEN_W-16){1'b0}}, off_cand} > produced;

  // next state
  always_comb begin
    phase_next      = phase;
    lit_left_next   = lit_left;
    match_ext_next  = match_ext;
    mlen_next       = mlen;
    moff_next       = moff;
    copy_left_next  = copy_left;
    produced_next   = produced;
    ending_next     = ending;
    discarding_next = discarding;
    fin             = 1'b0;
    fin_code        = ERR_OK;
    emit_lit        = 1'b0;
    emit_hist       = 1'b0;

    if (cmd == 1'b0) begin
      if (discarding) begin
        if (is_last) begin
          discarding_next = 1'b0;
        end
      end else begin
        case (phase)
          PH_TOKEN, PH_LITEXT: begin
            lit_left_next = lit_cand;
            if (phase == PH_TOKEN) begin
              match_ext_next = (in_byte[3:0] == NIBBLE_EXT);
              mlen_next      = {{(LEN_W-4){1'b0}}, in_byte[3:0]} + MIN_MATCH;
            end
            if ((phase == PH_TOKEN) ? (in_byte[7:4] == NIBBLE_EXT)
                                    : (in_byte == BYTE_EXT)) begin
              if (is_last) begin
                fin = 1'b1;
                fin_code = ERR_MALFORM;
              end else begin
                phase_next = PH_LITEXT;
              end
            end else if (lit_cand == '0) begin
              if (is_last) begin
                fin = 1'b1;
              end else begin
                phase_next = PH_OFFLO;
              end
            end else if (lit_over) begin
              fin = 1'b1;
              fin_code = ERR_CAPACITY;
            end else if (is_last) begin
              fin = 1'b1;
              fin_code = ERR_MALFORM;
            end else begin
              phase_next = PH_LITERAL;
            end
          end
          PH_LITERAL: begin
            if (is_last && (lit_left > 25'd1)) begin
              fin = 1'b1;
              fin_code = ERR_MALFORM;
            end else begin
              emit_lit      = 1'b1;
              produced_next = LEN_W'(produced + 25'd1);
              lit_left_next = LEN_W'(lit_left - 25'd1);
              if (lit_left == 25'd1) begin
                if (is_last) begin
                  fin = 1'b1;
                end else begin
                  phase_next = PH_OFFLO;
                end
              end
            end
          end
          PH_OFFLO: begin
            if (is_last) begin
              fin = 1'b1;
              fin_code = ERR_MALFORM;
            end else begin
              moff_next  = {8'd0, in_byte};
              phase_next = PH_OFFHI;
            end
          end
          PH_OFFHI, PH_MATEXT: begin
            if (phase == PH_OFFHI) begin
              moff_next = off_new;
            end else begin
              mlen_next = len_cand;
            end
            if ((phase == PH_OFFHI) && (off_new == 16'd0)) begin
              fin = 1'b1;
              fin_code = ERR_MALFORM;
            end else if ((phase == PH_OFFHI) ? match_ext : (in_byte == BYTE_EXT)) begin
              if (is_last) begin
                fin = 1'b1;
                fin_code = ERR_MALFORM;
              end else begin
                phase_next = PH_MATEXT;
              end
            end else if (off_bad) begin
              fin = 1'b1;
              fin_code = ERR_MALFORM;
            end else if (len_over) begin
              fin = 1'b1;
              fin_code = ERR_CAPACITY;
            end else begin
              copy_left_next = len_cand;
              ending_next    = is_last;
              phase_next     = PH_COPY;
            end
          end
          PH_COPY: begin
            fin = 1'b1;
            fin_code = ERR_BUSY;
          end
          default: begin
            fin = 1'b1;
            fin_code = ERR_MALFORM;
          end
        endcase
      end
    end else if (!discarding && (phase == PH_COPY)) begin
      emit_hist      = 1'b1;
      produced_next  = LEN_W'(produced + 25'd1);
      copy_left_next = LEN_W'(copy_left - 25'd1);
      if (copy_left == 25'd1) begin
        if (ending) begin
          fin = 1'b1;
        end else begin
          phase_next = PH_TOKEN;
        end
      end
    end

    // end of block: clear, and drop the rest of a failed block
    if (fin) begin
      phase_next      = PH_TOKEN;
      lit_left_next   = '0;
      match_ext_next  = 1'b0;
      mlen_next       = '0;
      moff_next       = '0;
      copy_left_next  = '0;
      produced_next   = '0;
      ending_next     = 1'b0;
      discarding_next = (fin_code != ERR_OK) && !is_last;
    end
  end

  // result of the accepted request
  always_comb begin
    s2_next       = '0;
    s2_next.wr    = emit_lit || emit_hist;
    s2_next.hist  = emit_hist;
    s2_next.lit   = in_byte;
    // a block that ends on its last literal shows no byte
    s2_next.show  = emit_hist || (emit_lit && !fin);
    s2_next.done  = fin;
    s2_next.err   = fin_code;
    s2_next.total = (emit_lit || emit_hist) ? LEN_W'(produced + 25'd1) : produced;
    s2_next.wants = (phase_next != PH_COPY) || discarding_next;
  end

  assign raddr = produced[AW-1:0] - AW'(moff);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TOKEN;
      lit_left   <= '0;
      match_ext  <= 1'b0;
      mlen       <= '0;
      moff       <= '0;
      copy_left  <= '0;
      produced   <= '0;
      ending     <= 1'b0;
      discarding <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      lit_left   <= lit_left_next;
      match_ext  <= match_ext_next;
      mlen       <= mlen_next;
      moff       <= moff_next;
      copy_left  <= copy_left_next;
      produced   <= produced_next;
      ending     <= ending_next;
      discarding <= discarding_next;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2       <= s2_next;
      s2_waddr <= produced[AW-1:0];
      // the byte leaving now is written at this edge, after the read
      fwd_hit  <= s2_move && s2.wr && (s2_waddr == raddr);
      fwd_byte <= s2_wdata;
    end
  end

  assign hist_data = fwd_hit ? fwd_byte : rdata;
  assign s2_wdata  = s2.hist ? hist_data : s2.lit;

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= history[raddr];
    end
    if (s2_move && s2.wr) begin
      history[s2_waddr] <= s2_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_move) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_valid  <= s2.show;
      out_byte   <= s2.show ? s2_wdata : 8'd0;
      block_done <= s2.done;
      error_code <= s2.err;
      out_total  <= s2.total;
      wants_byte <= s2.wants;
    end
  end

endmodule
